@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/lzg_pkg.sv @@
package lzg_pkg;

    localparam int HISTORY_DEPTH_DEF = 16384;
    localparam int LEN_W             = 32;
    localparam int COPY_W            = 7;
    localparam int DIST_W            = 14;

    localparam logic [2:0] HEADER_BYTES    = 3'd4;
    localparam logic [3:0] GROUPS_PER_FLAG = 4'd8;
    localparam logic [7:0] MODE_MAX        = 8'd3;
    localparam int         FLAG_MSB        = 7;

    typedef enum logic [1:0] {
        MODE_RAW    = 2'd0,
        MODE_GROUP1 = 2'd1,
        MODE_GROUP2 = 2'd2,
        MODE_GROUP4 = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        STATUS_OK       = 3'd0,
        STATUS_BAD_MODE = 3'd1,
        STATUS_LENGTH   = 3'd2,
        STATUS_BAD_DIST = 3'd3,
        STATUS_TRUNC    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COPY_RD,
        ST_COPY_WR
    } lzg_state_t;

endpackage

@@ rtl/lzg_in_if.sv @@
interface lzg_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_last;

    modport source (output valid, output in_byte, output is_last, input ready);
    modport sink   (input valid, input in_byte, input is_last, output ready);

endinterface

@@ rtl/lzg_out_if.sv @@
interface lzg_out_if;

    logic             valid;
    logic             ready;
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic             done_res;
    lzg_pkg::status_t status;

    modport source (output valid, output out_byte, output byte_valid, output done_res,
                    output status, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input done_res,
                    input status, output ready);

endinterface

@@ rtl/lzg_ram.sv @@
module lzg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lzg_pkg::HISTORY_DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/lzss_group_decompressor.sv @@
// lzss group decompressor
// comp channel: one compressed byte per transfer (in_byte, is_last). The first
// four bytes of a stream are the header; the first header byte selects raw copy
// or 1-, 2- or 4-byte literal groups.
// decomp channel: one transfer per decompressed byte; the last transfer of the
// item that carries is_last has done_res set and the stream status. When that
// item yields no byte, a single transfer with byte_valid low carries the status.
// cfg_wr_en / cfg_wr_data write the expected output length; the user must write
// it between items, the block does not enforce that. A result sits in the output
// register in the cycle after its transfer. Header, flag and literal bytes come
// in while the output register hands the previous result off. A back reference
// copies its bytes one at a time (history memory read, then write and output),
// up to 64 bytes; comp.ready stays low meanwhile.
// Reset clears all stream state and the expected length to zero; the history
// memory is not cleared, a reference never reaches bytes not yet written.
// A stalled decomp channel holds the output register, pauses the copy sequencer
// and keeps comp.ready low.
`include "assert_macros.svh"

module lzss_group_decompressor #(
    parameter int HISTORY_DEPTH = lzg_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [lzg_pkg::LEN_W-1:0]  cfg_wr_data,
    lzg_in_if.sink                     comp,
    lzg_out_if.source                  decomp
);

    import lzg_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);

    lzg_state_t         state_reg, state_next;
    logic [LEN_W-1:0]   expected_reg, expected_next;
    mode_t              mode_reg, mode_next;
    logic [2:0]         hdr_count_reg, hdr_count_next;
    logic [7:0]         flags_reg, flags_next;
    logic [3:0]         groups_left_reg, groups_left_next;
    logic               ref_phase_reg, ref_phase_next;
    logic [7:0]         ref_first_reg, ref_first_next;
    logic [1:0]         lit_left_reg, lit_left_next;
    logic [LEN_W-1:0]   bytes_out_reg, bytes_out_next;
    status_t            err_reg, err_next;
    logic [AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [COPY_W-1:0]  copy_left_reg, copy_left_next;
    logic               last_pending_reg, last_pending_next;

    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               out_bvalid_reg, out_bvalid_next;
    logic               out_done_reg, out_done_next;
    status_t            out_status_reg, out_status_next;

    logic               accept;
    logic               out_free;
    logic               room;
    logic [LEN_W-1:0]   bytes_inc;
    logic [1:0]         shift;
    logic [2:0]         bias;
    logic [1:0]         gsize_m1;
    logic [DIST_W-1:0]  ref_dist;
    logic               dist_bad;
    logic [COPY_W-1:0]  ref_total;
    logic [AW:0]        rd_diff;
    logic [AW-1:0]      rd_start;
    logic [AW-1:0]      wr_ptr_inc;
    logic [AW-1:0]      rd_ptr_inc;
    logic               copy_last;
    logic               emit;
    logic               elem_done;
    logic               stream_end;
    logic               ram_we;
    logic               ram_re;
    logic [7:0]         ram_wdata;
    logic [7:0]         ram_rdata;

    assign accept    = comp.valid && comp.ready;
    assign out_free  = !out_valid_reg || decomp.ready;
    assign comp.ready = (state_reg == ST_IDLE) && out_free;

    assign room      = bytes_out_reg < expected_reg;
    assign bytes_inc = bytes_out_reg + LEN_W'(1);
    assign shift     = 2'(mode_reg) - 2'd1;

    always_comb
    begin
        unique case (mode_reg)
            MODE_GROUP1:
            begin
                bias     = 3'd3;
                gsize_m1 = 2'd0;
            end
            MODE_GROUP2:
            begin
                bias     = 3'd2;
                gsize_m1 = 2'd1;
            end
            MODE_GROUP4:
            begin
                bias     = 3'd1;
                gsize_m1 = 2'd3;
            end
            default:
            begin
                bias     = 3'd0;
                gsize_m1 = 2'd0;
            end
        endcase
    end

    // reference decode: distance and copy length scaled by group size
    assign ref_dist  = DIST_W'({ref_first_reg[3:0], comp.in_byte}) << shift;
    assign ref_total = (COPY_W'(ref_first_reg[7:4]) + COPY_W'(bias)) << shift;
    assign dist_bad  = (ref_dist == '0)
                    || ({{(LEN_W-DIST_W){1'b0}}, ref_dist} > bytes_out_reg)
                    || ({{(LEN_W-DIST_W){1'b0}}, ref_dist} > LEN_W'(HISTORY_DEPTH));

    assign rd_diff    = {1'b0, wr_ptr_reg} - (AW+1)'(ref_dist);
    assign rd_start   = rd_diff[AW] ? AW'(rd_diff + (AW+1)'(HISTORY_DEPTH)) : rd_diff[AW-1:0];
    assign wr_ptr_inc = (wr_ptr_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
    assign rd_ptr_inc = (rd_ptr_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
    assign copy_last  = (copy_left_reg == COPY_W'(1)) || (bytes_inc == expected_reg);

    always_comb
    begin
        state_next        = state_reg;
        expected_next     = cfg_wr_en ? cfg_wr_data : expected_reg;
        mode_next         = mode_reg;
        hdr_count_next    = hdr_count_reg;
        flags_next        = flags_reg;
        groups_left_next  = groups_left_reg;
        ref_phase_next    = ref_phase_reg;
        ref_first_next    = ref_first_reg;
        lit_left_next     = lit_left_reg;
        bytes_out_next    = bytes_out_reg;
        err_next          = err_reg;
        wr_ptr_next       = wr_ptr_reg;
        rd_ptr_next       = rd_ptr_reg;
        copy_left_next    = copy_left_reg;
        last_pending_next = last_pending_reg;
        out_valid_next    = decomp.ready ? 1'b0 : out_valid_reg;
        out_byte_next     = out_byte_reg;
        out_bvalid_next   = out_bvalid_reg;
        out_done_next     = out_done_reg;
        out_status_next   = out_status_reg;
        emit              = 1'b0;
        elem_done         = 1'b0;
        stream_end        = 1'b0;
        ram_we            = 1'b0;
        ram_re            = 1'b0;
        ram_wdata         = comp.in_byte;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (err_reg == STATUS_OK)
                    begin
                        priority if (hdr_count_reg < HEADER_BYTES)
                        begin
                            if (hdr_count_reg == 3'd0)
                            begin
                                if (comp.in_byte > MODE_MAX)
                                begin
                                    err_next = STATUS_BAD_MODE;
                                end
                                else
                                begin
                                    mode_next = mode_t'(comp.in_byte[1:0]);
                                end
                            end
                            hdr_count_next = hdr_count_reg + 3'd1;
                        end
                        else if (mode_reg == MODE_RAW)
                        begin
                            emit = room;
                        end
                        else if (ref_phase_reg)
                        begin
                            ref_phase_next = 1'b0;
                            priority if (dist_bad)
                            begin
                                err_next = STATUS_BAD_DIST;
                            end
                            else if (!room)
                            begin
                                err_next = STATUS_LENGTH;
                            end
                            else
                            begin
                                state_next        = ST_COPY_RD;
                                copy_left_next    = ref_total;
                                rd_ptr_next       = rd_start;
                                last_pending_next = comp.is_last;
                            end
                        end
                        else if (lit_left_reg != 2'd0)
                        begin
                            if (!room)
                            begin
                                err_next = STATUS_LENGTH;
                            end
                            else
                            begin
                                emit          = 1'b1;
                                lit_left_next = lit_left_reg - 2'd1;
                                elem_done     = (lit_left_reg == 2'd1);
                            end
                        end
                        else if (!room)
                        begin
                            err_next = STATUS_LENGTH;
                        end
                        else if (groups_left_reg == 4'd0)
                        begin
                            flags_next       = comp.in_byte;
                            groups_left_next = GROUPS_PER_FLAG;
                        end
                        else if (flags_reg[FLAG_MSB])
                        begin
                            ref_phase_next = 1'b1;
                            ref_first_next = comp.in_byte;
                        end
                        else
                        begin
                            emit          = 1'b1;
                            lit_left_next = gsize_m1;
                            elem_done     = (gsize_m1 == 2'd0);
                        end
                    end

                    if (emit)
                    begin
                        ram_we          = 1'b1;
                        bytes_out_next  = bytes_inc;
                        wr_ptr_next     = wr_ptr_inc;
                        out_valid_next  = 1'b1;
                        out_byte_next   = comp.in_byte;
                        out_bvalid_next = 1'b1;
                        out_done_next   = 1'b0;
                        out_status_next = STATUS_OK;
                    end

                    if (comp.is_last && (state_next == ST_IDLE))
                    begin
                        stream_end     = 1'b1;
                        out_valid_next = 1'b1;
                        out_done_next  = 1'b1;
                        if (!emit)
                        begin
                            out_byte_next   = 8'h00;
                            out_bvalid_next = 1'b0;
                        end
                        priority if (err_next != STATUS_OK)
                        begin
                            out_status_next = err_next;
                        end
                        else if (hdr_count_next < HEADER_BYTES)
                        begin
                            out_status_next = STATUS_TRUNC;
                        end
                        else if (mode_next == MODE_RAW)
                        begin
                            out_status_next = (bytes_out_next < expected_reg) ? STATUS_TRUNC
                                                                               : STATUS_OK;
                        end
                        else if (ref_phase_next || (lit_left_next != 2'd0))
                        begin
                            out_status_next = STATUS_TRUNC;
                        end
                        else if (bytes_out_next != expected_reg)
                        begin
                            out_status_next = STATUS_LENGTH;
                        end
                        else
                        begin
                            out_status_next = STATUS_OK;
                        end
                    end
                end
            end

            ST_COPY_RD:
            begin
                ram_re      = 1'b1;
                rd_ptr_next = rd_ptr_inc;
                state_next  = ST_COPY_WR;
            end

            ST_COPY_WR:
            begin
                ram_wdata = ram_rdata;
                if (out_free)
                begin
                    ram_we          = 1'b1;
                    bytes_out_next  = bytes_inc;
                    wr_ptr_next     = wr_ptr_inc;
                    copy_left_next  = copy_left_reg - COPY_W'(1);
                    out_valid_next  = 1'b1;
                    out_byte_next   = ram_rdata;
                    out_bvalid_next = 1'b1;
                    out_done_next   = 1'b0;
                    out_status_next = STATUS_OK;
                    if (copy_last)
                    begin
                        state_next = ST_IDLE;
                        if (copy_left_reg == COPY_W'(1))
                        begin
                            elem_done = 1'b1;
                        end
                        else
                        begin
                            // next byte would pass the expected length
                            err_next = STATUS_LENGTH;
                        end
                        if (last_pending_reg)
                        begin
                            stream_end    = 1'b1;
                            out_done_next = 1'b1;
                            out_status_next = ((copy_left_reg == COPY_W'(1))
                                               && (bytes_inc == expected_reg)) ? STATUS_OK
                                                                               : STATUS_LENGTH;
                        end
                    end
                    else
                    begin
                        state_next = ST_COPY_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (elem_done)
        begin
            flags_next = {flags_reg[6:0], 1'b0};
            if (groups_left_reg != 4'd0)
            begin
                groups_left_next = groups_left_reg - 4'd1;
            end
        end

        if (stream_end)
        begin
            mode_next         = MODE_RAW;
            hdr_count_next    = '0;
            flags_next        = '0;
            groups_left_next  = '0;
            ref_phase_next    = 1'b0;
            ref_first_next    = '0;
            lit_left_next     = '0;
            bytes_out_next    = '0;
            err_next          = STATUS_OK;
            wr_ptr_next       = '0;
            last_pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            expected_reg     <= '0;
            mode_reg         <= MODE_RAW;
            hdr_count_reg    <= '0;
            flags_reg        <= '0;
            groups_left_reg  <= '0;
            ref_phase_reg    <= 1'b0;
            ref_first_reg    <= '0;
            lit_left_reg     <= '0;
            bytes_out_reg    <= '0;
            err_reg          <= STATUS_OK;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            copy_left_reg    <= '0;
            last_pending_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_byte_reg     <= '0;
            out_bvalid_reg   <= 1'b0;
            out_done_reg     <= 1'b0;
            out_status_reg   <= STATUS_OK;
        end
        else
        begin
            state_reg        <= state_next;
            expected_reg     <= expected_next;
            mode_reg         <= mode_next;
            hdr_count_reg    <= hdr_count_next;
            flags_reg        <= flags_next;
            groups_left_reg  <= groups_left_next;
            ref_phase_reg    <= ref_phase_next;
            ref_first_reg    <= ref_first_next;
            lit_left_reg     <= lit_left_next;
            bytes_out_reg    <= bytes_out_next;
            err_reg          <= err_next;
            wr_ptr_reg       <= wr_ptr_next;
            rd_ptr_reg       <= rd_ptr_next;
            copy_left_reg    <= copy_left_next;
            last_pending_reg <= last_pending_next;
            out_valid_reg    <= out_valid_next;
            out_byte_reg     <= out_byte_next;
            out_bvalid_reg   <= out_bvalid_next;
            out_done_reg     <= out_done_next;
            out_status_reg   <= out_status_next;
        end
    end

    lzg_ram #(
        .WIDTH (8),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (wr_ptr_reg),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rdata)
    );

    assign decomp.valid      = out_valid_reg;
    assign decomp.out_byte   = out_byte_reg;
    assign decomp.byte_valid = out_bvalid_reg;
    assign decomp.done_res   = out_done_reg;
    assign decomp.status     = out_status_reg;

    `ASSERT_IMPLY(a_copy_nonzero, clk, rst_n, state_reg != ST_IDLE, copy_left_reg != '0)
    `ASSERT_IMPLY(a_status_only_done, clk, rst_n, decomp.valid && !decomp.done_res,
                  decomp.status == STATUS_OK)
    `ASSERT_IMPLY(a_empty_is_final, clk, rst_n, decomp.valid && !decomp.byte_valid,
                  decomp.done_res)
    `ASSERT_NEXT(a_copy_emits, clk, rst_n, state_reg == ST_COPY_WR && out_free,
                 decomp.valid && decomp.byte_valid)
    `ASSERT_IMPLY(a_hdr_bound, clk, rst_n, 1'b1, hdr_count_reg <= HEADER_BYTES)

endmodule
